/* src/tlik_pkg.sv */
// shared types, constants and helper functions of the two-link arm solver
`default_nettype none
package tlik_pkg;

	localparam int Z_W = 34;
	localparam int SQ_SHIFT = 28;
	localparam logic signed [Z_W-1:0] HALF_PI_R = 34'sd1686629713;
	localparam logic [31:0] DEG_PER_RAD = 32'd3845054675;

	// configuration register indexes
	localparam logic [2:0] REG_UPPER_LINK = 3'd0;
	localparam logic [2:0] REG_LOWER_LINK = 3'd1;
	localparam logic [2:0] REG_BASE_ROT = 3'd2;
	localparam logic [2:0] REG_BASE_OFF = 3'd3;
	localparam logic [2:0] REG_SHOULDER_OFF = 3'd4;
	localparam logic [2:0] REG_ELBOW_OFF = 3'd5;

	localparam logic OP_SOLVE = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// operands of one vectoring run
	typedef struct packed {
		logic [63:0] ym;
		logic yneg;
		logic [63:0] xm;
		logic xneg;
	} vec_req_t;

	// arctangent of 2^-i in radians with 30 fraction bits
	function automatic logic signed [Z_W-1:0] arc(input logic [5:0] i);
		logic signed [Z_W-1:0] r;
		begin
			unique case (i)
				6'd0: r = 34'sd843314857;
				6'd1: r = 34'sd497837829;
				6'd2: r = 34'sd263043837;
				6'd3: r = 34'sd133525159;
				6'd4: r = 34'sd67021687;
				6'd5: r = 34'sd33543516;
				6'd6: r = 34'sd16775851;
				6'd7: r = 34'sd8388437;
				6'd8: r = 34'sd4194283;
				6'd9: r = 34'sd2097149;
				6'd10: r = 34'sd1048576;
				default: begin
					if (i <= 6'd30) r = 34'sd1 <<< (6'd30 - i);
					else r = '0;
				end
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		else if (v < -66'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

endpackage
`default_nettype wire

/* src/tlik_sqrt.sv */
// bit-serial integer square root, two radicand bits per cycle
`default_nettype none
module tlik_sqrt import tlik_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] radicand,
	output logic done,
	output logic [31:0] root
);
	logic busy_q, done_q;
	logic [4:0] cnt_q;
	logic [63:0] v_q, r_q, b_q, t;

	assign t = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
			b_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= t) begin
				v_q <= v_q - t;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];
endmodule
`default_nettype wire

/* src/tlik_cordic.sv */
// iterative vectoring cordic giving atan2 in radians with 30 fraction bits
`default_nettype none
module tlik_cordic import tlik_pkg::*; #(
	parameter int STEPS = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire vec_req_t req,
	output logic done,
	output logic signed [Z_W-1:0] angle
);
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);
	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_PRE = 2'd1;
	localparam logic [1:0] C_ITER = 2'd2;

	logic [1:0] st_q;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;
	logic [63:0] xm_q, ym_q;
	logic xneg_q, yneg_q;
	logic signed [63:0] x_q, y_q, dx, dy;
	logic signed [Z_W-1:0] z_q;
	logic [5:0] idx;
	logic big;

	assign idx = 6'(cnt_q);
	assign dx = y_q >>> idx;
	assign dy = x_q >>> idx;
	assign big = (xm_q[63:60] != 4'd0) || (ym_q[63:60] != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				C_IDLE: if (start) st_q <= C_PRE;
				C_PRE: begin
					if (!big) begin
						cnt_q <= '0;
						if (xm_q == 64'd0 && ym_q == 64'd0) begin
							done_q <= 1'b1;
							st_q <= C_IDLE;
						end else begin
							st_q <= C_ITER;
						end
					end
				end
				C_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						done_q <= 1'b1;
						st_q <= C_IDLE;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == C_IDLE && start) begin
			xm_q <= req.xm;
			ym_q <= req.ym;
			xneg_q <= req.xneg;
			yneg_q <= req.yneg;
		end else if (st_q == C_PRE) begin
			if (big) begin
				xm_q <= xm_q >> 1;
				ym_q <= ym_q >> 1;
			end else if (xm_q == 64'd0 && ym_q == 64'd0) begin
				z_q <= '0;
			end else if (xneg_q && xm_q != 64'd0) begin
				// negative x: turn a quarter toward the right half plane
				x_q <= $signed(ym_q);
				if (yneg_q && ym_q != 64'd0) begin
					y_q <= -$signed(xm_q);
					z_q <= -HALF_PI_R;
				end else begin
					y_q <= $signed(xm_q);
					z_q <= HALF_PI_R;
				end
			end else begin
				x_q <= $signed(xm_q);
				y_q <= yneg_q ? -$signed(ym_q) : $signed(ym_q);
				z_q <= '0;
			end
		end else if (st_q == C_ITER) begin
			if (!y_q[63]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + arc(idx);
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - arc(idx);
			end
		end
	end

	assign done = done_q;
	assign angle = z_q;
endmodule
`default_nettype wire

/* src/two_link_arm_inverse_kinematics_unit.sv */
// two-link planar arm solver with joint state and servo set-point outputs
//
// input channel (in_valid/in_ready): one request per item; opcode 0 solves the
// target point (target_x, target_y), opcode 1 loads shoulder_set and elbow_set.
// output channel (out_valid/out_ready): one result per request with the rounded
// base, shoulder, elbow and accumulated elbow angles plus offsets, and the
// unreachable flag (state kept when set).
// config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while no request is in flight.
// a solve runs two square roots, three runs of the shared cordic of CORDIC_STEPS
// iterations each (longer while operands are prescaled) and the degree conversion;
// a rejected target and a direct load skip these steps. one request is in work at
// a time; in_ready is high only in the idle state.
// a finished result waits in the output register; a new request is accepted
// while it waits, and the block holds its finished result until that register
// frees. reset clears the joint state, loads the register defaults (links
// 20480, all else zero) and empties the output register.
`default_nettype none
module two_link_arm_inverse_kinematics_unit import tlik_pkg::*; #(
	parameter int COORD_WIDTH = 18,
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int CORDIC_STEPS = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [24:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic opcode,
	input wire logic signed [COORD_WIDTH-1:0] target_x,
	input wire logic signed [COORD_WIDTH-1:0] target_y,
	input wire logic signed [25:0] shoulder_set,
	input wire logic signed [25:0] elbow_set,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [10:0] base_servo,
	output logic signed [10:0] shoulder_servo,
	output logic signed [10:0] elbow_servo,
	output logic signed [15:0] elbow_accum_servo,
	output logic unreachable
);
	localparam int DEG_SH = 56 - ANGLE_FRAC_BITS;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_SQX = 5'd1;
	localparam logic [4:0] ST_SQY = 5'd2;
	localparam logic [4:0] ST_SQ1 = 5'd3;
	localparam logic [4:0] ST_SQ2 = 5'd4;
	localparam logic [4:0] ST_SQD = 5'd5;
	localparam logic [4:0] ST_SQS = 5'd6;
	localparam logic [4:0] ST_CHK = 5'd7;
	localparam logic [4:0] ST_RA = 5'd8;
	localparam logic [4:0] ST_WA = 5'd9;
	localparam logic [4:0] ST_RB = 5'd10;
	localparam logic [4:0] ST_WB = 5'd11;
	localparam logic [4:0] ST_MK = 5'd12;
	localparam logic [4:0] ST_KK = 5'd13;
	localparam logic [4:0] ST_RE = 5'd14;
	localparam logic [4:0] ST_WE = 5'd15;
	localparam logic [4:0] ST_RAL = 5'd16;
	localparam logic [4:0] ST_WAL = 5'd17;
	localparam logic [4:0] ST_RBT = 5'd18;
	localparam logic [4:0] ST_WBT = 5'd19;
	localparam logic [4:0] ST_DG1 = 5'd20;
	localparam logic [4:0] ST_DG2 = 5'd21;
	localparam logic [4:0] ST_DG3 = 5'd22;
	localparam logic [4:0] ST_DG4 = 5'd23;
	localparam logic [4:0] ST_APPLY = 5'd24;
	localparam logic [4:0] ST_OUT = 5'd25;

	// configuration
	logic [15:0] l1_q, l2_q;
	logic signed [24:0] base_rot_q;
	logic signed [8:0] base_off_q, sh_off_q, el_off_q;

	// joint state
	logic signed [31:0] sh_ang_q, el_ang_q, acc_q;

	logic [4:0] st_q;
	logic flag_q, out_valid_q;
	logic [COORD_WIDTH-1:0] xm_q, ym_q;
	logic yneg_q;
	logic [63:0] prod_q, hh_q, lo_q, hi_q, l1sq_q, l2sq_q, k_q;
	logic [31:0] sa_q, sb_q;
	logic signed [37:0] d_q, e_q;
	logic signed [Z_W-1:0] elb_q, al_q, sum_q;
	logic signed [31:0] n1_q, n2_q;
	logic signed [10:0] base_o_q, sh_o_q, el_o_q;
	logic signed [15:0] acc_o_q;
	logic unr_o_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_d;
	logic [15:0] dl;
	logic [16:0] lsum;

	assign dl = (l1_q > l2_q) ? l1_q - l2_q : l2_q - l1_q;
	assign lsum = {1'b0, l1_q} + {1'b0, l2_q};

	// radian to degree conversion
	logic signed [Z_W-1:0] deg_src;
	logic deg_neg;
	logic [Z_W-1:0] deg_mag;
	logic [33:0] deg_hi;
	logic [63:0] deg_full, deg_q;
	logic signed [65:0] deg_val;
	logic signed [31:0] deg_ang;

	assign deg_src = (st_q == ST_DG1 || st_q == ST_DG2) ? sum_q : elb_q;
	assign deg_neg = deg_src[Z_W-1];
	assign deg_mag = deg_neg ? Z_W'(-deg_src) : Z_W'(deg_src);
	assign deg_hi = 34'(deg_mag[33:32]) * 34'(DEG_PER_RAD);
	assign deg_full = prod_q + {deg_hi[31:0], 32'd0} + (64'd1 << (DEG_SH - 1));
	assign deg_q = deg_full >> DEG_SH;
	assign deg_val = deg_neg ? -$signed({2'b00, deg_q}) : $signed({2'b00, deg_q});
	assign deg_ang = sat32(deg_val);

	always_comb begin
		unique case (st_q)
			ST_SQX: begin mul_a = 32'(xm_q); mul_b = 32'(xm_q); end
			ST_SQY: begin mul_a = 32'(ym_q); mul_b = 32'(ym_q); end
			ST_SQ1: begin mul_a = 32'(l1_q); mul_b = 32'(l1_q); end
			ST_SQ2: begin mul_a = 32'(l2_q); mul_b = 32'(l2_q); end
			ST_SQD: begin mul_a = 32'(dl); mul_b = 32'(dl); end
			ST_SQS: begin mul_a = 32'(lsum); mul_b = 32'(lsum); end
			ST_MK: begin mul_a = sa_q; mul_b = sb_q; end
			ST_DG1, ST_DG3: begin mul_a = deg_mag[31:0]; mul_b = DEG_PER_RAD; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// square root unit
	logic sq_start, sq_done;
	logic [63:0] sq_rad;
	logic [31:0] sq_root;

	assign sq_start = (st_q == ST_RA) || (st_q == ST_RB);
	assign sq_rad = (st_q == ST_RA) ? (hh_q - lo_q) << SQ_SHIFT : (hi_q - hh_q) << SQ_SHIFT;

	tlik_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.radicand(sq_rad),
		.done(sq_done),
		.root(sq_root)
	);

	// cordic unit
	logic cr_start, cr_done;
	vec_req_t cr_req;
	logic signed [Z_W-1:0] cr_angle;
	logic [37:0] dm, em;

	assign dm = d_q[37] ? 38'(-d_q) : 38'(d_q);
	assign em = e_q[37] ? 38'(-e_q) : 38'(e_q);
	assign cr_start = (st_q == ST_RE) || (st_q == ST_RAL) || (st_q == ST_RBT);

	always_comb begin
		unique case (st_q)
			ST_RE: begin
				cr_req.ym = k_q;
				cr_req.yneg = 1'b0;
				cr_req.xm = 64'(dm) << SQ_SHIFT;
				cr_req.xneg = d_q[37];
			end
			ST_RAL: begin
				cr_req.ym = k_q;
				cr_req.yneg = 1'b0;
				cr_req.xm = 64'(em) << SQ_SHIFT;
				cr_req.xneg = 1'b0;
			end
			default: begin
				cr_req.ym = 64'(ym_q);
				cr_req.yneg = yneg_q;
				cr_req.xm = 64'(xm_q);
				cr_req.xneg = 1'b0;
			end
		endcase
	end

	tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cr_start),
		.req(cr_req),
		.done(cr_done),
		.angle(cr_angle)
	);

	// joint update
	logic signed [33:0] dd;
	logic signed [65:0] acc_sum;
	logic reach_bad;

	assign dd = (34'(n1_q) - 34'(sh_ang_q)) + (34'(n2_q) - 34'(el_ang_q));
	assign acc_sum = 66'(acc_q) + 66'(dd);
	assign reach_bad = (l1_q == 16'd0) || (l2_q == 16'd0) || (hh_q == 64'd0) ||
		(hh_q < lo_q) || (hh_q > prod_q);

	// output values
	function automatic logic signed [33:0] rnd_ang(input logic signed [31:0] v);
		logic signed [32:0] ve;
		logic [32:0] m, q;
		begin
			ve = 33'(v);
			m = v[31] ? 33'(-ve) : 33'(ve);
			q = (m + (33'd1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
			return v[31] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		end
	endfunction

	function automatic logic signed [10:0] sat11(input logic signed [33:0] v);
		if (v > 34'sd1023) return 11'sd1023;
		else if (v < -34'sd1024) return -11'sd1024;
		else return v[10:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
		if (v > 34'sd32767) return 16'sh7fff;
		else if (v < -34'sd32768) return 16'sh8000;
		else return v[15:0];
	endfunction

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= 16'd20480;
			l2_q <= 16'd20480;
			base_rot_q <= '0;
			base_off_q <= '0;
			sh_off_q <= '0;
			el_off_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_UPPER_LINK: l1_q <= cfg_data[15:0];
				REG_LOWER_LINK: l2_q <= cfg_data[15:0];
				REG_BASE_ROT: base_rot_q <= cfg_data;
				REG_BASE_OFF: base_off_q <= cfg_data[8:0];
				REG_SHOULDER_OFF: sh_off_q <= cfg_data[8:0];
				REG_ELBOW_OFF: el_off_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			flag_q <= 1'b0;
			out_valid_q <= 1'b0;
			sh_ang_q <= '0;
			el_ang_q <= '0;
			acc_q <= '0;
		end else begin
			// load a new result or keep the one still waiting
			out_valid_q <= (st_q == ST_OUT && out_free) || (out_valid_q && !out_ready);
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						flag_q <= 1'b0;
						st_q <= (opcode == OP_LOAD) ? ST_APPLY : ST_SQX;
					end
				end
				ST_SQX: st_q <= ST_SQY;
				ST_SQY: st_q <= ST_SQ1;
				ST_SQ1: st_q <= ST_SQ2;
				ST_SQ2: st_q <= ST_SQD;
				ST_SQD: st_q <= ST_SQS;
				ST_SQS: st_q <= ST_CHK;
				ST_CHK: begin
					if (reach_bad) begin
						flag_q <= 1'b1;
						st_q <= ST_OUT;
					end else begin
						st_q <= ST_RA;
					end
				end
				ST_RA: st_q <= ST_WA;
				ST_WA: if (sq_done) st_q <= ST_RB;
				ST_RB: st_q <= ST_WB;
				ST_WB: if (sq_done) st_q <= ST_MK;
				ST_MK: st_q <= ST_KK;
				ST_KK: st_q <= ST_RE;
				ST_RE: st_q <= ST_WE;
				ST_WE: if (cr_done) st_q <= ST_RAL;
				ST_RAL: st_q <= ST_WAL;
				ST_WAL: if (cr_done) st_q <= ST_RBT;
				ST_RBT: st_q <= ST_WBT;
				ST_WBT: if (cr_done) st_q <= ST_DG1;
				ST_DG1: st_q <= ST_DG2;
				ST_DG2: st_q <= ST_DG3;
				ST_DG3: st_q <= ST_DG4;
				ST_DG4: st_q <= ST_APPLY;
				ST_APPLY: begin
					sh_ang_q <= n1_q;
					el_ang_q <= n2_q;
					acc_q <= sat32(acc_sum);
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		unique case (st_q)
			ST_IDLE: begin
				xm_q <= target_x[COORD_WIDTH-1] ? COORD_WIDTH'(-target_x) :
					COORD_WIDTH'(target_x);
				ym_q <= target_y[COORD_WIDTH-1] ? COORD_WIDTH'(-target_y) :
					COORD_WIDTH'(target_y);
				yneg_q <= target_y[COORD_WIDTH-1];
				n1_q <= 32'(shoulder_set);
				n2_q <= 32'(elbow_set);
			end
			ST_SQY: hh_q <= prod_q;
			ST_SQ1: hh_q <= hh_q + prod_q;
			ST_SQ2: l1sq_q <= prod_q;
			ST_SQD: l2sq_q <= prod_q;
			ST_SQS: lo_q <= prod_q;
			ST_CHK: hi_q <= prod_q;
			ST_WA: if (sq_done) sa_q <= sq_root;
			ST_WB: if (sq_done) sb_q <= sq_root;
			ST_KK: begin
				k_q <= prod_q;
				d_q <= $signed(38'(l1sq_q)) + $signed(38'(l2sq_q)) - $signed(38'(hh_q));
				e_q <= $signed(38'(l1sq_q)) + $signed(38'(hh_q)) - $signed(38'(l2sq_q));
			end
			ST_WE: if (cr_done) elb_q <= cr_angle;
			ST_WAL: if (cr_done) al_q <= cr_angle;
			ST_WBT: if (cr_done) sum_q <= cr_angle + al_q;
			ST_DG2: n1_q <= deg_ang;
			ST_DG4: n2_q <= deg_ang;
			ST_OUT: begin
				if (out_free) begin
					base_o_q <= sat11(rnd_ang(32'(base_rot_q)) + 34'(base_off_q));
					sh_o_q <= sat11(rnd_ang(sh_ang_q) + 34'(sh_off_q));
					el_o_q <= sat11(rnd_ang(el_ang_q) + 34'(el_off_q));
					acc_o_q <= sat16(rnd_ang(acc_q) + 34'(el_off_q));
					unr_o_q <= flag_q;
				end
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign base_servo = base_o_q;
	assign shoulder_servo = sh_o_q;
	assign elbow_servo = el_o_q;
	assign elbow_accum_servo = acc_o_q;
	assign unreachable = unr_o_q;
endmodule
`default_nettype wire

/* bench/two_link_arm_inverse_kinematics_unit_tb.sv */
// self-checking testbench for the two-link arm inverse kinematics unit
`timescale 1ns / 100ps
`default_nettype none
module two_link_arm_inverse_kinematics_unit_tb;
	import tlik_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int CYCLE_LIMIT = 1200000;
	localparam int STALL_LEN = 400;
	localparam longint ANG_MAX = 23592960;

	typedef struct {
		logic op;
		logic signed [17:0] tx;
		logic signed [17:0] ty;
		logic signed [25:0] sh;
		logic signed [25:0] el;
	} arm_req_t;

	typedef struct {
		longint base;
		longint shoulder;
		longint elbow;
		longint accum;
		logic flag;
	} servo_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [24:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_SOLVE;
	logic signed [17:0] target_x = '0;
	logic signed [17:0] target_y = '0;
	logic signed [25:0] shoulder_set = '0;
	logic signed [25:0] elbow_set = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [10:0] base_servo;
	logic signed [10:0] shoulder_servo;
	logic signed [10:0] elbow_servo;
	logic signed [15:0] elbow_accum_servo;
	logic unreachable;

	two_link_arm_inverse_kinematics_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.target_x(target_x), .target_y(target_y),
		.shoulder_set(shoulder_set), .elbow_set(elbow_set),
		.out_valid(out_valid), .out_ready(out_ready),
		.base_servo(base_servo), .shoulder_servo(shoulder_servo), .elbow_servo(elbow_servo),
		.elbow_accum_servo(elbow_accum_servo), .unreachable(unreachable)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	arm_req_t arm_req_q[$];
	servo_t servo_expect_q[$];
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_req_cnt = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cfg_write_cnt = 0;
	int err_cnt = 0;
	int result_cnt = 0;
	int reject_cnt = 0;
	int cycle_cnt = 0;
	logic in_fire = 1'b0;

	// joint state and register copies
	bit [15:0] l1_len, l2_len;
	bit [24:0] base_rot;
	bit [8:0] base_off, shoulder_off, elbow_off;
	longint shoulder_ang, elbow_ang, accum_ang;

	function automatic longint clip(longint v, int bits);
		longint hi, lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic bit [63:0] int_root(bit [63:0] v);
		bit [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint arc_step(int i);
		longint tab[11] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576};
		if (i < 11) return tab[i];
		if (i <= 30) return longint'(1) <<< (30 - i);
		return 0;
	endfunction

	function automatic longint vector_angle(bit [63:0] ym, bit yneg, bit [63:0] xm, bit xneg);
		longint x, y, z, t, dx, dy;
		z = 0;
		while (xm >= (64'd1 << 60) || ym >= (64'd1 << 60)) begin
			xm = xm >> 1;
			ym = ym >> 1;
		end
		if (xm == 0 && ym == 0) return 0;
		x = xneg ? -longint'(xm) : longint'(xm);
		y = yneg ? -longint'(ym) : longint'(ym);
		// left half plane: pre-rotate by a quarter turn
		if (x < 0) begin
			if (y >= 0) begin
				t = y; y = -x; x = t; z = HALF_PI_R;
			end else begin
				t = -y; y = x; x = t; z = -HALF_PI_R;
			end
		end
		for (int i = 0; i < 20; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arc_step(i);
			end else begin
				x -= dx; y += dy; z -= arc_step(i);
			end
		end
		return z;
	endfunction

	function automatic longint rad_to_deg(longint r);
		bit [63:0] m, q;
		m = r < 0 ? 64'(-r) : 64'(r);
		q = (m * 64'(DEG_PER_RAD) + (64'd1 << 39)) >> 40;
		return r < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint round_deg(longint v);
		bit [63:0] m, q;
		m = v < 0 ? 64'(-v) : 64'(v);
		q = (m + 64'd32768) >> 16;
		return v < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic void move_joints(longint a1, longint a2);
		longint n1, n2, d;
		n1 = clip(a1, 32);
		n2 = clip(a2, 32);
		d = (n1 - shoulder_ang) + (n2 - elbow_ang);
		shoulder_ang = n1;
		elbow_ang = n2;
		accum_ang = clip(accum_ang + d, 32);
	endfunction

	function automatic servo_t solve_arm(arm_req_t rq);
		servo_t s;
		longint x, y, d, e, elb, alpha, beta, eoff;
		bit [63:0] xm, ym, hh, l1, l2, dl, lo, hi, k, dm, em;
		s.flag = 1'b0;
		if (rq.op == OP_LOAD) move_joints(longint'(rq.sh), longint'(rq.el));
		else begin
			x = longint'(rq.tx);
			y = longint'(rq.ty);
			xm = x < 0 ? 64'(-x) : 64'(x);
			ym = y < 0 ? 64'(-y) : 64'(y);
			hh = xm * xm + ym * ym;
			l1 = 64'(l1_len);
			l2 = 64'(l2_len);
			dl = l1 > l2 ? l1 - l2 : l2 - l1;
			lo = dl * dl;
			hi = (l1 + l2) * (l1 + l2);
			if (l1 == 0 || l2 == 0 || hh == 0 || hh < lo || hh > hi) s.flag = 1'b1;
			else begin
				k = int_root((hh - lo) << SQ_SHIFT) * int_root((hi - hh) << SQ_SHIFT);
				d = longint'(l1 * l1 + l2 * l2) - longint'(hh);
				e = longint'(l1 * l1 + hh) - longint'(l2 * l2);
				dm = d < 0 ? 64'(-d) : 64'(d);
				em = e < 0 ? 64'(-e) : 64'(e);
				elb = vector_angle(k, 1'b0, dm << SQ_SHIFT, d < 0);
				alpha = vector_angle(k, 1'b0, em << SQ_SHIFT, 1'b0);
				beta = vector_angle(ym, y < 0, xm, 1'b0);
				move_joints(rad_to_deg(beta + alpha), rad_to_deg(elb));
			end
		end
		eoff = longint'($signed(elbow_off));
		s.base = clip(round_deg(longint'($signed(base_rot))) + longint'($signed(base_off)), 11);
		s.shoulder = clip(round_deg(shoulder_ang) + longint'($signed(shoulder_off)), 11);
		s.elbow = clip(round_deg(elbow_ang) + eoff, 11);
		s.accum = clip(round_deg(accum_ang) + eoff, 16);
		return s;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (arst_n && arm_req_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				arm_req_t rq;
				rq = arm_req_q.pop_front();
				opcode <= rq.op;
				target_x <= rq.tx;
				target_y <= rq.ty;
				shoulder_set <= rq.sh;
				elbow_set <= rq.el;
				in_valid <= 1'b1;
			end else in_valid <= 1'b0;
		end
	end

	// result receiver with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req_cnt != hold_seen) begin
			hold_seen <= hold_req_cnt;
			hold_left <= STALL_LEN;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, servo_expect_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_UPPER_LINK: l1_len = cfg_data[15:0];
				REG_LOWER_LINK: l2_len = cfg_data[15:0];
				REG_BASE_ROT: base_rot = cfg_data;
				REG_BASE_OFF: base_off = cfg_data[8:0];
				REG_SHOULDER_OFF: shoulder_off = cfg_data[8:0];
				REG_ELBOW_OFF: elbow_off = cfg_data[8:0];
				default: ;
			endcase
			cfg_write_cnt <= cfg_write_cnt + 1;
		end
		if (arst_n && in_valid && in_ready) begin
			arm_req_t rq;
			rq = '{opcode, target_x, target_y, shoulder_set, elbow_set};
			servo_expect_q.push_back(solve_arm(rq));
		end
		if (arst_n && out_valid && out_ready) begin
			result_cnt <= result_cnt + 1;
			if (servo_expect_q.size() == 0) begin
				$display("%0t unexpected result base %0d shoulder %0d", $time,
					base_servo, shoulder_servo);
				err_cnt <= err_cnt + 1;
			end else begin
				servo_t s;
				s = servo_expect_q.pop_front();
				if (s.flag) reject_cnt <= reject_cnt + 1;
				if (longint'(base_servo) != s.base || longint'(shoulder_servo) != s.shoulder ||
						longint'(elbow_servo) != s.elbow ||
						longint'(elbow_accum_servo) != s.accum || unreachable != s.flag) begin
					$display("%0t mismatch expected base %0d shoulder %0d elbow %0d accum %0d flag %0b",
						$time, s.base, s.shoulder, s.elbow, s.accum, s.flag);
					$display("%0t          actual base %0d shoulder %0d elbow %0d accum %0d flag %0b",
						$time, base_servo, shoulder_servo, elbow_servo, elbow_accum_servo,
						unreachable);
					err_cnt <= err_cnt + 1;
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [24:0] val);
		int seen;
		seen = cfg_write_cnt;
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (cfg_write_cnt == seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_solve(longint x, longint y);
		arm_req_q.push_back('{OP_SOLVE, 18'(x), 18'(y), 26'($urandom), 26'($urandom)});
	endtask

	task automatic push_load(longint a, longint b);
		arm_req_q.push_back('{OP_LOAD, 18'($urandom), 18'($urandom), 26'(a), 26'(b)});
	endtask

	function automatic longint rand_span(longint lim);
		return longint'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	task automatic push_random(int n);
		longint reach;
		reach = longint'(l1_len) + longint'(l2_len);
		if (reach > 131071) reach = 131071;
		if (reach < 2) reach = 2;
		repeat (n) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 65) push_solve(rand_span(reach), rand_span(reach));
			else if (pick < 75) push_solve(rand_span(131072), rand_span(131072));
			else if (pick < 95) push_load(rand_span(ANG_MAX), rand_span(ANG_MAX));
			else push_load(longint'($signed(26'($urandom))), longint'($signed(26'($urandom))));
		end
	endtask

	task automatic drain();
		wait (arm_req_q.size() == 0 && !in_valid && servo_expect_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		longint ph[8][6] = '{
			'{20480, 20480, 0, 0, 0, 0},
			'{65535, 65535, 11796480, 180, 180, 180},
			'{1, 1, -11796480, -180, -180, -180},
			'{30000, 12000, 5000000, 17, -90, 45},
			'{8000, 40000, -3276800, -5, 60, -120},
			'{0, 20480, 65536, 1, -1, 2},
			'{65535, 1, 32768, -33, 99, -7},
			'{20480, 20480, -32768, 0, 0, 0}
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// state after reset
		l1_len = 20480; l2_len = 20480; base_rot = '0;
		base_off = '0; shoulder_off = '0; elbow_off = '0;
		shoulder_ang = 0; elbow_ang = 0; accum_ang = 0;

		// directed: reach bounds, origin, extremes, both operations
		push_solve(0, 0);
		push_solve(40960, 0);
		push_solve(0, 40960);
		push_solve(-40960, 0);
		push_solve(0, -40960);
		push_solve(40961, 0);
		push_solve(-131072, -131072);
		push_solve(131071, 131071);
		push_solve(-20000, 15000);
		push_solve(-20000, -15000);
		push_solve(20000, -15000);
		push_solve(1, 0);
		push_load(ANG_MAX, ANG_MAX);
		push_load(-ANG_MAX, -ANG_MAX);
		push_load(33554431, -33554432);
		push_load(-33554432, 33554431);
		push_load(0, 0);
		push_load(32768, -32768);
		push_load(-98304, 98303);
		push_solve(28963, 0);
		drain();

		for (int p = 0; p < 8; p++) begin
			for (int r = 0; r < 6; r++)
				write_reg(3'(r), 25'(ph[p][r]));
			if (p == 7) write_reg(3'd6, 25'($urandom));
			send_gap_pct = (p % 4 == 1) ? 59 : (p % 4 == 3 ? 28 : 0);
			recv_stall_pct = (p % 4 == 2) ? 59 : (p % 4 == 3 ? 28 : 0);
			if (p == 1 || p == 2) begin
				push_solve(longint'(l1_len) + longint'(l2_len), 0);
				push_solve(0, 0);
				push_solve(-131072, 131071);
			end
			push_random(p == 5 ? 60 : 135);
			// the receiver goes quiet while the sender keeps offering requests
			if (p == 1) hold_req_cnt = hold_req_cnt + 1;
			drain();
		end
		repeat (200) @(posedge clk);
		$display("covered %0d results over 8 register settings, %0d targets rejected",
			result_cnt, reject_cnt);
		if (err_cnt == 0 && servo_expect_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
src/tlik_pkg.sv
src/tlik_sqrt.sv
src/tlik_cordic.sv
src/two_link_arm_inverse_kinematics_unit.sv
bench/two_link_arm_inverse_kinematics_unit_tb.sv
